>>> rtl/sha256_pkg.sv
// Shared types, round constants and round functions of the SHA-256 hasher.
`default_nettype none

package sha256_pkg;

	typedef logic [31:0] word_t;

	localparam int ROUNDS      = 64;
	localparam int BLOCK_WORDS = 16;
	localparam int CHAIN_WORDS = 8;

	localparam logic [7:0] PAD_BYTE     = 8'h80;
	// word slot where the 64-bit length starts (byte offset 56)
	localparam logic [3:0] LEN_WORD_POS = 4'd14;

	localparam word_t ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t CHAIN_IV [CHAIN_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		logic absorb;
		logic clear;
	} pack_ctrl_t;

	typedef struct packed {
		logic load;
		logic step;
	} sched_ctrl_t;

	typedef struct packed {
		logic init;
		logic step;
		logic fold;
		logic restart;
	} round_ctrl_t;

	function automatic word_t rotr(word_t x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sigma0(word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t choose(word_t e, word_t f, word_t g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic word_t major(word_t a, word_t b, word_t c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

`default_nettype wire

>>> rtl/sha256_if.sv
// Valid/ready channel interfaces for message input and digest output.
`default_nettype none

interface sha256_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        end_of_message;

	modport source(output valid, data_word, byte_count, end_of_message, input ready);
	modport sink(input valid, data_word, byte_count, end_of_message, output ready);
endinterface

interface sha256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic        last_digest_word;

	modport source(output valid, digest_word, last_digest_word, input ready);
	modport sink(input valid, digest_word, last_digest_word, output ready);
endinterface

`default_nettype wire

>>> rtl/sha256_pack.sv
// Byte packer: gathers 0..4 bytes per word into whole 32-bit message words.
`default_nettype none

module sha256_pack (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha256_pkg::pack_ctrl_t ctrl,
	input  sha256_pkg::word_t      data_word,
	input  logic [2:0]             byte_count,
	output logic [2:0]             valid_bytes,
	output logic                   emit,
	output sha256_pkg::word_t      emit_word,
	output sha256_pkg::word_t      pad_word
);
	import sha256_pkg::*;

	logic [23:0] part_q;
	logic [1:0]  held_q;

	word_t       masked;
	logic [55:0] merged;
	logic [2:0]  total;
	logic [23:0] part_d;

	always_comb begin
		valid_bytes = (byte_count > 3'd4) ? 3'd4 : byte_count;
		masked      = data_word & ~(32'hffff_ffff >> {valid_bytes, 3'b000});
		// held bytes on top, new bytes right after them
		merged      = {part_q, 32'h0} | ({masked, 24'h0} >> {held_q, 3'b000});
		total       = {1'b0, held_q} + valid_bytes;
		emit        = total[2];
		emit_word   = merged[55:24];
		part_d      = emit ? merged[23:0] : merged[55:32];
		pad_word    = {part_q, 8'h00} | ({PAD_BYTE, 24'h0} >> {held_q, 3'b000});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
			held_q <= '0;
		end else if (ctrl.clear) begin
			part_q <= '0;
			held_q <= '0;
		end else if (ctrl.absorb) begin
			part_q <= part_d;
			held_q <= total[1:0];
		end
	end

endmodule

`default_nettype wire

>>> rtl/sha256_sched.sv
// Message schedule: 16-word window that is filled by loads and expanded per round.
`default_nettype none

module sha256_sched (
	input  logic                    clk,
	input  sha256_pkg::sched_ctrl_t ctrl,
	input  sha256_pkg::word_t       load_word,
	output sha256_pkg::word_t       sched_word
);
	import sha256_pkg::*;

	// win_q[0] is W[t], win_q[15] is W[t+15]
	word_t win_q [BLOCK_WORDS];
	word_t next_word;

	always_comb begin
		if (ctrl.step) begin
			next_word = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
		end else begin
			next_word = load_word;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load || ctrl.step) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[BLOCK_WORDS - 1] <= next_word;
		end
	end

	assign sched_word = win_q[0];

endmodule

`default_nettype wire

>>> rtl/sha256_round.sv
// Compression round unit with working variables and chaining words.
`default_nettype none

module sha256_round (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sha256_pkg::round_ctrl_t ctrl,
	input  logic [5:0]              round_idx,
	input  sha256_pkg::word_t       sched_word,
	input  logic [2:0]              digest_idx,
	output sha256_pkg::word_t       digest_word
);
	import sha256_pkg::*;

	word_t chain_q [CHAIN_WORDS];
	word_t var_q   [CHAIN_WORDS];
	word_t t1;
	word_t t2;

	always_comb begin
		t1 = var_q[7] + big_sigma1(var_q[4]) + choose(var_q[4], var_q[5], var_q[6])
			+ ROUND_K[round_idx] + sched_word;
		t2 = big_sigma0(var_q[0]) + major(var_q[0], var_q[1], var_q[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= CHAIN_IV;
		end else if (ctrl.restart) begin
			chain_q <= CHAIN_IV;
		end else if (ctrl.fold) begin
			for (int i = 0; i < CHAIN_WORDS; i++) begin
				chain_q[i] <= chain_q[i] + var_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			var_q <= chain_q;
		end else if (ctrl.step) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

	assign digest_word = chain_q[digest_idx];

endmodule

`default_nettype wire

>>> rtl/sha256_hasher.sv
// SHA-256 hasher top level: byte packer, schedule, round unit and sequencer.
// An input word is taken only in the idle state; the word that completes a 64-byte
// block starts a compression (64 rounds through the shared round unit, one fold),
// and no new word is accepted until that compression has folded.
// A closing word adds the padding and length words, one or two compressions
// and eight digest words, one per cycle while the sink is ready.
// Reset is asynchronous: chaining words return to the initial hash, counts clear.
`default_nettype none

module sha256_hasher (
	input logic          clk,
	input logic          arst_n,
	sha256_in_if.sink    msg,
	sha256_out_if.source digest
);
	import sha256_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_ZERO,
		S_LEN_LO,
		S_COMP,
		S_FOLD,
		S_OUT
	} state_t;

	state_t      state_q, state_d;
	state_t      resume_q, resume_d;
	state_t      after;
	logic [3:0]  words_q;
	logic [5:0]  round_q;
	logic [2:0]  out_idx_q;
	logic [63:0] bits_q;

	logic        in_fire;
	logic        out_fire;
	logic        push;
	logic        wrap;
	word_t       push_word;

	pack_ctrl_t  pctl;
	sched_ctrl_t sctl;
	round_ctrl_t rctl;

	logic [2:0]  valid_bytes;
	logic        emit;
	word_t       emit_word;
	word_t       pad_word;
	word_t       sched_word;

	assign msg.ready               = (state_q == S_IDLE);
	assign in_fire                 = msg.valid && msg.ready;
	assign digest.valid            = (state_q == S_OUT);
	assign digest.last_digest_word = &out_idx_q;
	assign out_fire                = digest.valid && digest.ready;

	sha256_pack u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (pctl),
		.data_word  (msg.data_word),
		.byte_count (msg.byte_count),
		.valid_bytes(valid_bytes),
		.emit       (emit),
		.emit_word  (emit_word),
		.pad_word   (pad_word)
	);

	sha256_sched u_sched (
		.clk       (clk),
		.ctrl      (sctl),
		.load_word (push_word),
		.sched_word(sched_word)
	);

	sha256_round u_round (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (rctl),
		.round_idx  (round_q),
		.sched_word (sched_word),
		.digest_idx (out_idx_q),
		.digest_word(digest.digest_word)
	);

	always_comb begin
		push      = 1'b0;
		push_word = emit_word;
		after     = state_q;
		pctl      = '0;
		sctl      = '0;
		rctl      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					pctl.absorb = 1'b1;
					push        = emit;
					after       = msg.end_of_message ? S_PAD : S_IDLE;
				end
			end
			S_PAD: begin
				push      = 1'b1;
				push_word = pad_word;
				pctl.clear = 1'b1;
				after     = S_ZERO;
			end
			S_ZERO: begin
				push = 1'b1;
				if (words_q == LEN_WORD_POS) begin
					push_word = bits_q[63:32];
					after     = S_LEN_LO;
				end else begin
					push_word = '0;
					after     = S_ZERO;
				end
			end
			S_LEN_LO: begin
				push      = 1'b1;
				push_word = bits_q[31:0];
				after     = S_OUT;
			end
			S_COMP: begin
				rctl.step = 1'b1;
				sctl.step = 1'b1;
				after     = (round_q == 6'(ROUNDS - 1)) ? S_FOLD : S_COMP;
			end
			S_FOLD: begin
				rctl.fold = 1'b1;
				after     = resume_q;
			end
			S_OUT: begin
				if (out_fire && (&out_idx_q)) begin
					rctl.restart = 1'b1;
					after        = S_IDLE;
				end
			end
			default: after = S_IDLE;
		endcase

		// sixteenth word of a block starts a compression
		wrap      = push && (&words_q);
		sctl.load = push;
		rctl.init = wrap;
		state_d   = wrap ? S_COMP : after;
		resume_d  = wrap ? after : resume_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			resume_q  <= S_IDLE;
			words_q   <= '0;
			round_q   <= '0;
			out_idx_q <= '0;
			bits_q    <= '0;
		end else begin
			state_q  <= state_d;
			resume_q <= resume_d;
			if (push) begin
				words_q <= words_q + 4'd1;
			end
			if (state_q == S_COMP) begin
				round_q <= round_q + 6'd1;
			end
			if (out_fire) begin
				out_idx_q <= out_idx_q + 3'd1;
			end
			if (rctl.restart) begin
				bits_q <= '0;
			end else if (in_fire) begin
				bits_q <= bits_q + {58'h0, valid_bytes, 3'b000};
			end
		end
	end

endmodule

`default_nettype wire
